// ===== hw/rtl/battery_runtime_estimator_core_defines.svh =====
// Assertion helpers included by the core RTL file.
// The clock is clk and the reset is rst in every scope that uses them.
`ifndef BATTERY_RUNTIME_ESTIMATOR_CORE_DEFINES_SVH
`define BATTERY_RUNTIME_ESTIMATOR_CORE_DEFINES_SVH

// Consequence must hold in the same cycle as the antecedent.
`define BRE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define BRE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/bre_pkg.sv =====
`default_nettype none

package bre_pkg;

  localparam int ChargeW  = 15;
  localparam int MvW      = 16;
  localparam int EpochW   = 32;
  localparam int DaysW    = 24;
  localparam int ThreshW  = 10;
  localparam int MinElapW = 16;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  // Division operands: the numerator is charge * elapsed * 256.
  localparam int ProdW    = ChargeW + EpochW;
  localparam int NumW     = ProdW + 8;
  localparam int DenW     = 32;
  localparam int DivSteps = NumW;
  localparam int StepW    = $clog2(DivSteps);

  localparam logic [16:0] SecPerDay = 17'd86400;

  localparam logic [ThreshW-1:0]  RiseResetMv   = 10'd40;
  localparam logic [ThreshW-1:0]  DropResetMv   = 10'd40;
  localparam logic [MinElapW-1:0] MinElapReset  = 16'd900;
  localparam logic [ChargeW-1:0]  MinDropReset  = 15'd512;

  localparam int JobDepthDef = 4;
  localparam int ResDepthDef = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RISE     = 2'd0,
    CFG_DROP     = 2'd1,
    CFG_MIN_ELAP = 2'd2,
    CFG_MIN_DROP = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [ThreshW-1:0]  rise_threshold_mv;
    logic [ThreshW-1:0]  drop_threshold_mv;
    logic [MinElapW-1:0] min_elapsed_sec;
    logic [ChargeW-1:0]  min_drop_q8;
  } cfg_t;

  typedef struct packed {
    logic [ChargeW-1:0] charge_pct_q8;
    logic [MvW-1:0]     cell_mv;
    logic [EpochW-1:0]  epoch_sec;
  } sample_t;

  typedef struct packed {
    logic [DaysW-1:0] days_left_q8;
    logic             estimate_valid;
    logic             is_charging;
    logic             entered_charge;
  } result_t;

  // Snapshot of the tracker state after one sample, handed to the back end.
  typedef struct packed {
    logic               baseline_seen;
    logic               charging;
    logic               entered;
    logic [ChargeW-1:0] base_charge;
    logic [EpochW-1:0]  base_time;
    logic [ChargeW-1:0] last_charge;
    logic [EpochW-1:0]  last_time;
  } job_t;

endpackage

`default_nettype wire

// ===== hw/rtl/battery_runtime_estimator_core.sv =====
// Channel   Direction  Handshake               Word
// sample    in         push / full             charge, cell mV, epoch seconds
// result    out        pop / empty             days left, valid, charging, entered
// config    in         cfg_valid / cfg_ready   register index, write data
//
// The front end takes one sample per cycle while full is low and updates the tracker state at once.
// Each estimate passes the back end in order: fetch, check, multiply, the one-bit-per-step
// divider, deliver; an invalid estimate goes from check straight to deliver.
// The back end takes no new job until the current estimate is delivered.
// full rises once the job queue fills; a stalled result holds the back end.
// Sync reset clears control and tracker state, not data words; no clearing pass is needed.
`default_nettype none

`include "battery_runtime_estimator_core_defines.svh"

module battery_runtime_estimator_core #(
  parameter int JobDepth = bre_pkg::JobDepthDef,
  parameter int ResDepth = bre_pkg::ResDepthDef
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  bre_pkg::sample_t                sample,
  output logic                            empty,
  input  logic                            pop,
  output bre_pkg::result_t                result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bre_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [bre_pkg::CfgDataW-1:0]    cfg_data
);

  import bre_pkg::*;

  cfg_t    cfg;
  job_t    front_job;
  job_t    head_job;
  result_t back_res;
  logic    accept;
  logic    job_rd;
  logic    job_empty;
  logic    res_wr;
  logic    res_full;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rise_threshold_mv <= RiseResetMv;
      cfg.drop_threshold_mv <= DropResetMv;
      cfg.min_elapsed_sec   <= MinElapReset;
      cfg.min_drop_q8       <= MinDropReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_e'(cfg_index))
        CFG_RISE:     cfg.rise_threshold_mv <= cfg_data[ThreshW-1:0];
        CFG_DROP:     cfg.drop_threshold_mv <= cfg_data[ThreshW-1:0];
        CFG_MIN_ELAP: cfg.min_elapsed_sec   <= cfg_data[MinElapW-1:0];
        CFG_MIN_DROP: cfg.min_drop_q8       <= cfg_data[ChargeW-1:0];
        default: begin
        end
      endcase
    end
  end

  bre_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .sample (sample),
    .cfg    (cfg),
    .job    (front_job)
  );

  bre_queue #(
    .Width ($bits(job_t)),
    .Depth (JobDepth)
  ) u_job_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (accept),
    .wr_data (front_job),
    .rd      (job_rd),
    .rd_data (head_job),
    .full    (full),
    .empty   (job_empty)
  );

  bre_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_empty (job_empty),
    .job       (head_job),
    .job_rd    (job_rd),
    .res_full  (res_full),
    .res_wr    (res_wr),
    .res       (back_res)
  );

  bre_queue #(
    .Width ($bits(result_t)),
    .Depth (ResDepth)
  ) u_res_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (res_wr),
    .wr_data (back_res),
    .rd      (pop),
    .rd_data (result),
    .full    (res_full),
    .empty   (empty)
  );

  `BRE_ASSERT_IMP(a_invalid_zero, !empty && !result.estimate_valid,
                  result.days_left_q8 == '0, "invalid estimate carries nonzero days")
  `BRE_ASSERT_IMP(a_charge_invalid, !empty && result.is_charging,
                  !result.estimate_valid, "estimate marked valid while charging")
  `BRE_ASSERT_IMP(a_entered_charging, !empty && result.entered_charge,
                  result.is_charging, "charge entry reported without charging")
  `BRE_ASSERT_NXT(a_job_queued, push && !full, !job_empty,
                  "accepted sample did not reach the job queue")

endmodule

`default_nettype wire

// ===== hw/rtl/bre_queue.sv =====
`default_nettype none

module bre_queue #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [Width-1:0] wr_data,
  input  logic             rd,
  output logic [Width-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  logic [Width-1:0] entries [Depth];
  logic [AddrW-1:0] wr_ptr;
  logic [AddrW-1:0] rd_ptr;
  logic [CntW-1:0]  count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CntW'(Depth));
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AddrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AddrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bre_front.sv =====
`default_nettype none

module bre_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  bre_pkg::sample_t sample,
  input  bre_pkg::cfg_t   cfg,
  output bre_pkg::job_t   job
);

  import bre_pkg::*;

  typedef enum logic [2:0] {
    MODE_SETTLE = 3'b001,
    MODE_DRAIN  = 3'b010,
    MODE_FILL   = 3'b100
  } dir_e;

  logic               baseline_seen, baseline_seen_next;
  logic [ChargeW-1:0] base_charge, base_charge_next;
  logic [EpochW-1:0]  base_time, base_time_next;
  logic [ChargeW-1:0] last_charge, last_charge_next;
  logic [EpochW-1:0]  last_time, last_time_next;
  logic               detector_seen, detector_seen_next;
  logic [MvW-1:0]     pivot_mv, pivot_mv_next;
  dir_e               direction, direction_next;
  logic               entered;
  logic               rise_hit;
  logic               drop_hit;

  // Compare in 18 bits so that the threshold offsets never wrap.
  assign rise_hit = ({2'b00, sample.cell_mv} >=
                     ({2'b00, pivot_mv} + {8'b0, cfg.rise_threshold_mv}));
  assign drop_hit = ({2'b00, pivot_mv} >=
                     ({2'b00, sample.cell_mv} + {8'b0, cfg.drop_threshold_mv}));

  always_comb begin
    baseline_seen_next = baseline_seen;
    base_charge_next   = base_charge;
    base_time_next     = base_time;
    last_charge_next   = last_charge;
    last_time_next     = last_time;
    detector_seen_next = detector_seen;
    pivot_mv_next      = pivot_mv;
    direction_next     = direction;
    entered            = 1'b0;
    // A sample without a valid time leaves everything as it was.
    if (sample.epoch_sec != '0) begin
      if (!baseline_seen) begin
        baseline_seen_next = 1'b1;
        base_charge_next   = sample.charge_pct_q8;
        base_time_next     = sample.epoch_sec;
      end
      last_charge_next = sample.charge_pct_q8;
      last_time_next   = sample.epoch_sec;
      priority if (!detector_seen) begin
        detector_seen_next = 1'b1;
        pivot_mv_next      = sample.cell_mv;
        direction_next     = MODE_SETTLE;
      end else if (rise_hit) begin
        entered        = (direction != MODE_FILL);
        direction_next = MODE_FILL;
        pivot_mv_next  = sample.cell_mv;
      end else if (drop_hit) begin
        direction_next = MODE_DRAIN;
        pivot_mv_next  = sample.cell_mv;
      end else begin
        pivot_mv_next = pivot_mv;
      end
      // Going into charge restarts the baseline at this sample.
      if (entered) begin
        base_charge_next = sample.charge_pct_q8;
        base_time_next   = sample.epoch_sec;
      end
    end
  end

  always_comb begin
    job.baseline_seen = baseline_seen_next;
    job.charging      = (direction_next == MODE_FILL);
    job.entered       = entered;
    job.base_charge   = base_charge_next;
    job.base_time     = base_time_next;
    job.last_charge   = last_charge_next;
    job.last_time     = last_time_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      baseline_seen <= 1'b0;
      base_charge   <= '0;
      base_time     <= '0;
      last_charge   <= '0;
      last_time     <= '0;
      detector_seen <= 1'b0;
      pivot_mv      <= '0;
      direction     <= MODE_SETTLE;
    end else if (accept) begin
      baseline_seen <= baseline_seen_next;
      base_charge   <= base_charge_next;
      base_time     <= base_time_next;
      last_charge   <= last_charge_next;
      last_time     <= last_time_next;
      detector_seen <= detector_seen_next;
      pivot_mv      <= pivot_mv_next;
      direction     <= direction_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bre_back.sv =====
`default_nettype none

module bre_back (
  input  logic             clk,
  input  logic             rst,
  input  bre_pkg::cfg_t    cfg,
  input  logic             job_empty,
  input  bre_pkg::job_t    job,
  output logic             job_rd,
  input  logic             res_full,
  output logic             res_wr,
  output bre_pkg::result_t res
);

  import bre_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_MUL   = 5'b00100,
    S_DIV   = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e             state;
  logic [EpochW-1:0]  elapsed;
  logic [ChargeW-1:0] consumed;
  logic [ChargeW-1:0] last_charge;
  logic               pre_ok;
  logic               charging;
  logic               entered;
  logic               est_ok;
  logic [DenW-1:0]    den;
  logic [NumW-1:0]    num;
  logic [DenW-1:0]    rem;
  logic [StepW-1:0]   step;
  logic [EpochW:0]    time_diff;
  logic [DenW:0]      rem_sh;
  logic               q_bit;
  logic [ProdW-1:0]   prod;
  logic               check_ok;

  assign job_rd    = (state == S_IDLE) && !job_empty;
  assign res_wr    = (state == S_DONE) && !res_full;
  assign time_diff = {1'b0, job.last_time} - {1'b0, job.base_time};
  assign check_ok  = pre_ok && ({16'b0, cfg.min_elapsed_sec} <= elapsed) &&
                     (consumed >= cfg.min_drop_q8);
  assign prod      = ProdW'(last_charge) * ProdW'(elapsed);
  // Restoring division: the numerator shifts out at the top while the
  // quotient bits shift in at the bottom of the same register.
  assign rem_sh    = {rem, num[NumW-1]};
  assign q_bit     = (rem_sh >= {1'b0, den});

  always_comb begin
    res.estimate_valid = est_ok;
    res.is_charging    = charging;
    res.entered_charge = entered;
    if (!est_ok) begin
      res.days_left_q8 = '0;
    end else if (|num[NumW-1:DaysW]) begin
      res.days_left_q8 = '1;
    end else begin
      res.days_left_q8 = num[DaysW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (!job_empty) begin
          elapsed     <= time_diff[EpochW] ? '0 : time_diff[EpochW-1:0];
          consumed    <= job.base_charge - job.last_charge;
          last_charge <= job.last_charge;
          pre_ok      <= job.baseline_seen && !job.charging &&
                         (job.base_charge > job.last_charge);
          charging    <= job.charging;
          entered     <= job.entered;
        end
      end
      S_CHECK: begin
        est_ok <= check_ok;
        den    <= DenW'(consumed) * DenW'(SecPerDay);
      end
      S_MUL: begin
        num <= {prod, 8'b0};
        rem <= '0;
      end
      S_DIV: begin
        rem <= q_bit ? DenW'(rem_sh - {1'b0, den}) : rem_sh[DenW-1:0];
        num <= {num[NumW-2:0], q_bit};
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (!job_empty) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          state <= check_ok ? S_MUL : S_DONE;
        end
        S_MUL: begin
          step  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          step <= step + 1'b1;
          if (step == StepW'(DivSteps - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!res_full) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== dv/battery_runtime_estimator_core_tb.sv =====
`default_nettype none

module battery_runtime_estimator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bre_pkg::*;

  localparam int WatchdogLimit = 5000;
  localparam int HoldCycles    = 800;
  localparam int TailCycles    = 100;
  localparam int SettleCycles  = 70;

  typedef enum logic [1:0] {
    MODE_SETTLE = 2'd0,
    MODE_DRAIN  = 2'd1,
    MODE_FILL   = 2'd2
  } direction_e;

  // Tracks the estimator state and holds the estimates still owed by the block.
  class runtime_scoreboard;
    result_t           pending_estimates[$];
    int                errors;
    logic [ThreshW-1:0]  rise_mv;
    logic [ThreshW-1:0]  drop_mv;
    logic [MinElapW-1:0] min_elapsed;
    logic [ChargeW-1:0]  min_drop;
    logic                baseline_seen;
    logic                detector_seen;
    logic [ChargeW-1:0]  base_charge;
    logic [ChargeW-1:0]  last_charge;
    logic [EpochW-1:0]   base_time;
    logic [EpochW-1:0]   last_time;
    logic [MvW-1:0]      pivot_mv;
    direction_e          dir;

    function new();
      errors        = 0;
      rise_mv       = RiseResetMv;
      drop_mv       = DropResetMv;
      min_elapsed   = MinElapReset;
      min_drop      = MinDropReset;
      baseline_seen = 1'b0;
      detector_seen = 1'b0;
      base_charge   = '0;
      last_charge   = '0;
      base_time     = '0;
      last_time     = '0;
      pivot_mv      = '0;
      dir           = MODE_SETTLE;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_RISE:     rise_mv = data[ThreshW-1:0];
        CFG_DROP:     drop_mv = data[ThreshW-1:0];
        CFG_MIN_ELAP: min_elapsed = data[MinElapW-1:0];
        CFG_MIN_DROP: min_drop = data[ChargeW-1:0];
        default: ;
      endcase
    endfunction

    // Pivot ratchet: returns 1 when this voltage flips the direction into charging.
    function logic track_voltage(logic [MvW-1:0] mv);
      int   delta;
      logic flipped;
      flipped = 1'b0;
      if (!detector_seen) begin
        pivot_mv      = mv;
        dir           = MODE_SETTLE;
        detector_seen = 1'b1;
      end else begin
        delta = int'(mv) - int'(pivot_mv);
        if (delta >= int'(rise_mv)) begin
          flipped  = (dir != MODE_FILL);
          dir      = MODE_FILL;
          pivot_mv = mv;
        end else if (-delta >= int'(drop_mv)) begin
          dir      = MODE_DRAIN;
          pivot_mv = mv;
        end
      end
      return flipped;
    endfunction

    function result_t estimate_days();
      result_t          r;
      logic [EpochW-1:0]  elapsed;
      logic [ChargeW-1:0] consumed;
      logic [63:0]        num;
      logic [63:0]        den;
      logic [63:0]        q;
      r             = '0;
      r.is_charging = (dir == MODE_FILL);
      if (!baseline_seen || dir == MODE_FILL) return r;
      elapsed = (last_time >= base_time) ? last_time - base_time : '0;
      if (elapsed < 32'(min_elapsed)) return r;
      if (base_charge <= last_charge) return r;
      consumed = base_charge - last_charge;
      if (consumed < min_drop) return r;
      num = 64'(last_charge) * 64'(elapsed) * 64'd256;
      den = 64'(consumed) * 64'(SecPerDay);
      q   = num / den;
      r.days_left_q8   = (q > 64'hFF_FFFF) ? 24'hFF_FFFF : q[DaysW-1:0];
      r.estimate_valid = 1'b1;
      return r;
    endfunction

    function void note_sample(sample_t s);
      logic    entered;
      result_t r;
      entered = 1'b0;
      // A zero epoch leaves every piece of state alone.
      if (s.epoch_sec != '0) begin
        if (!baseline_seen) begin
          base_charge   = s.charge_pct_q8;
          base_time     = s.epoch_sec;
          baseline_seen = 1'b1;
        end
        last_charge = s.charge_pct_q8;
        last_time   = s.epoch_sec;
        entered     = track_voltage(s.cell_mv);
        if (entered) begin
          base_charge = s.charge_pct_q8;
          base_time   = s.epoch_sec;
        end
      end
      r                = estimate_days();
      r.entered_charge = entered;
      pending_estimates.push_back(r);
    endfunction

    function void check_estimate(result_t got);
      result_t want;
      if (pending_estimates.size() == 0) begin
        $error("result word with no estimate pending: %h", got);
        errors++;
        return;
      end
      want = pending_estimates.pop_front();
      if (got.days_left_q8 !== want.days_left_q8) begin
        $error("days_left_q8: expected %0d, actual %0d", want.days_left_q8, got.days_left_q8);
        errors++;
      end
      if (got.estimate_valid !== want.estimate_valid) begin
        $error("estimate_valid: expected %0d, actual %0d",
               want.estimate_valid, got.estimate_valid);
        errors++;
      end
      if (got.is_charging !== want.is_charging) begin
        $error("is_charging: expected %0d, actual %0d", want.is_charging, got.is_charging);
        errors++;
      end
      if (got.entered_charge !== want.entered_charge) begin
        $error("entered_charge: expected %0d, actual %0d",
               want.entered_charge, got.entered_charge);
        errors++;
      end
    endfunction

    function int pending();
      return pending_estimates.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                push = 1'b0;
  logic                full;
  sample_t             sample = '0;
  logic                empty;
  logic                pop = 1'b0;
  result_t             result;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  runtime_scoreboard sb = new();

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_pending = 1'b0;
  int idle_cycles = 0;

  // Discharge trace carried across phases.
  int          tr_charge = 25600;
  int          tr_mv = 4100;
  logic [31:0] tr_time = 32'd0;
  int          chg_left = 0;
  int          cur_rise = 40;
  int          cur_drop = 40;

  battery_runtime_estimator_core u_top (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .sample    (sample),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Values read here are the ones present just before the edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) sb.note_sample(sample);
      if (pop && !empty) sb.check_estimate(result);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_reg_e'(cfg_index), cfg_data);
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WatchdogLimit) begin
      $display("battery_runtime_estimator_core_tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (rst) begin
        pop <= 1'b0;
      end else if (hold_pending) begin
        hold_pending = 1'b0;
        pop <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_sample(input logic [ChargeW-1:0] charge, input logic [MvW-1:0] mv,
                             input logic [EpochW-1:0] epoch);
    int gap;
    gap = 0;
    sample <= '{charge_pct_q8: charge, cell_mv: mv, epoch_sec: epoch};
    push   <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    if (send_idle_pct != 0) begin
      if ($urandom_range(99) < 3) gap = $urandom_range(1, 150);
      else while ($urandom_range(99) < send_idle_pct) gap++;
    end
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_one(input cfg_reg_e idx, input logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic write_settings(input int rise, input int drop, input int elap, input int mdrop);
    write_one(CFG_RISE, CfgDataW'(rise));
    write_one(CFG_DROP, CfgDataW'(drop));
    write_one(CFG_MIN_ELAP, CfgDataW'(elap));
    write_one(CFG_MIN_DROP, CfgDataW'(mdrop));
    cfg_valid <= 1'b0;
    cur_rise = rise;
    cur_drop = drop;
  endtask

  // Mostly a plausible discharge trace with charger plug-ins; the rest is noise,
  // zero epochs and time running backwards.
  task automatic run_traffic(input int count, input int hold_at);
    int          pick;
    logic [31:0] epoch;
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_pending = 1'b1;
      pick = $urandom_range(99);
      if (pick < 8) begin
        epoch = ($urandom_range(3) == 0) ? 32'd0 : $urandom;
        send_sample(ChargeW'($urandom_range(25600)), MvW'($urandom), epoch);
      end else if (pick < 12) begin
        send_sample(ChargeW'($urandom_range(25600)), MvW'($urandom), 32'd0);
      end else if (pick < 15) begin
        send_sample(ChargeW'(tr_charge), MvW'(tr_mv), tr_time - $urandom_range(1, 5000));
      end else begin
        if (chg_left > 1) begin
          tr_mv     = tr_mv + $urandom_range(0, 50);
          tr_charge = tr_charge + $urandom_range(0, 150);
          chg_left--;
        end else if (chg_left == 1) begin
          tr_mv    = tr_mv - cur_drop - $urandom_range(0, 200);
          chg_left = 0;
        end else if (pick < 20 || tr_charge < 2000) begin
          // The plug-in sample already carries the high charge, so the new
          // baseline starts near full.
          tr_mv     = tr_mv + cur_rise + $urandom_range(0, 200);
          tr_charge = $urandom_range(18000, 25600);
          chg_left  = $urandom_range(1, 4);
        end else begin
          tr_charge = tr_charge - $urandom_range(0, 300);
          if ($urandom_range(9) == 0) tr_mv = tr_mv + $urandom_range(0, 20);
          else tr_mv = tr_mv - $urandom_range(0, 30);
        end
        if (tr_charge < 0) tr_charge = 0;
        if (tr_charge > 25600) tr_charge = 25600;
        if (tr_mv < 0) tr_mv = 0;
        if (tr_mv > 65535) tr_mv = 65535;
        if ($urandom_range(99) < 5) tr_time = tr_time + $urandom_range(1, 200000);
        else tr_time = tr_time + $urandom_range(1, 3600);
        send_sample(ChargeW'(tr_charge), MvW'(tr_mv), tr_time);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part under the reset settings.
    send_sample(15'd25600, 16'd65535, 32'd0);
    send_sample(15'd25600, 16'd4000, 32'd1000);
    send_sample(15'd25000, 16'd3990, 32'd1500);
    send_sample(15'd24000, 16'd3950, 32'd2000);
    send_sample(15'd0, 16'd0, 32'd0);
    send_sample(15'd23000, 16'd3945, 32'd1200);
    send_sample(15'd22000, 16'd3940, 32'd90000);
    send_sample(15'd22100, 16'd3990, 32'd90100);
    send_sample(15'd22300, 16'd4100, 32'd90200);
    send_sample(15'd22100, 16'd4000, 32'd100000);
    send_sample(15'd21000, 16'd3990, 32'd200000);
    send_sample(15'd21500, 16'd3985, 32'hFFFF_FFFF);
    send_sample(15'd0, 16'd3980, 32'hFFFF_FFFF);
    send_sample(15'd0, 16'd0, 32'hFFFF_FFFF);
    send_sample(15'd25600, 16'd65535, 32'd300000);
    send_sample(15'd25400, 16'd65000, 32'd400000);
    send_sample(15'd25000, 16'd64990, 32'd500000);
    send_sample(15'd25600, 16'd65535, 32'd0);
    send_sample(15'd24000, 16'd64000, 32'd100);

    tr_time = $urandom_range(1, 32'hF000_0000);

    wait_idle();
    write_settings(1, 1, 0, 0);
    run_traffic(150, -1);

    wait_idle();
    write_settings(1023, 1023, 65535, 25600);
    send_idle_pct = 57;
    run_traffic(150, -1);

    wait_idle();
    write_settings($urandom_range(1, 100), $urandom_range(1, 100),
                   $urandom_range(0, 4000), $urandom_range(0, 2000));
    send_idle_pct  = 0;
    recv_stall_pct = 57;
    run_traffic(150, 40);

    wait_idle();
    write_settings(40, 40, 900, 512);
    send_idle_pct  = 15;
    recv_stall_pct = 15;
    run_traffic(150, -1);

    wait_idle();
    write_settings($urandom_range(1, 1023), $urandom_range(1, 1023),
                   $urandom_range(0, 65535), $urandom_range(0, 25600));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_traffic(150, -1);

    push <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (sb.errors == 0) begin
      $display("battery_runtime_estimator_core_tb: done, clean");
    end else begin
      $display("battery_runtime_estimator_core_tb: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/bre_pkg.sv
hw/rtl/bre_queue.sv
hw/rtl/bre_front.sv
hw/rtl/bre_back.sv
hw/rtl/battery_runtime_estimator_core.sv
dv/battery_runtime_estimator_core_tb.sv
